// File: rtl/int8_euclidean_distance_assert.svh
// Assertion macros used by the controller.
`ifndef INT8_EUCLIDEAN_DISTANCE_ASSERT_SVH
`define INT8_EUCLIDEAN_DISTANCE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IED_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ied assertion failed");

// Next-cycle implication, disabled during reset.
`define IED_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ied assertion failed");

`endif

// File: rtl/ied_pkg.sv
package ied_pkg;

  localparam int ELEM_W     = 8;
  localparam int SQ_W       = 16;   // (255)^2 fits in 16 bits
  localparam int SUM_W      = 32;
  localparam int ROOT_W     = 24;   // sqrt of a 48-bit radicand
  localparam int REM_W      = ROOT_W + 2;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int CNT_W      = $clog2(ROOT_STEPS);

  typedef struct packed {
    logic accept;  // pair transfer this cycle
    logic start;   // transfer carries the last pair: launch the root
    logic step;    // one root digit
    logic load;    // move the root into the output register
  } cmd_t;

  typedef struct packed {
    logic root_last;  // current step produces the final root bit
  } sts_t;

endpackage

// File: rtl/ied_ifs.sv
interface ied_pair_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ied_pkg::ELEM_W-1:0]    elem_a;
  logic signed [ied_pkg::ELEM_W-1:0]    elem_b;
  logic                                 last_elem;

  modport source (output valid, elem_a, elem_b, last_elem, input ready);
  modport sink   (input valid, elem_a, elem_b, last_elem, output ready);
endinterface

interface ied_dist_if;
  logic                        valid;
  logic                        ready;
  logic [ied_pkg::ROOT_W-1:0]  distance;
  logic                        sum_saturated;

  modport source (output valid, distance, sum_saturated, input ready);
  modport sink   (input valid, distance, sum_saturated, output ready);
endinterface

// File: rtl/ied_datapath.sv
module ied_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  ied_pkg::cmd_t                      cmd,
  input  logic signed [ied_pkg::ELEM_W-1:0]  elem_a,
  input  logic signed [ied_pkg::ELEM_W-1:0]  elem_b,
  output ied_pkg::sts_t                      sts,
  output logic [ied_pkg::ROOT_W-1:0]         distance,
  output logic                               sum_saturated
);
  import ied_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic              ovf;
  logic [SUM_W-1:0]  xreg;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic              root_ovf;
  logic [CNT_W-1:0]  cnt;

  logic signed [ELEM_W:0]     diff;
  logic signed [2*ELEM_W+1:0] prod;
  logic [SQ_W-1:0]            sq;
  logic [SUM_W:0]             total;
  logic [SUM_W-1:0]           tot_sat;
  logic                       ovf_new;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;

  assign diff    = {elem_a[ELEM_W-1], elem_a} - {elem_b[ELEM_W-1], elem_b};
  assign prod    = diff * diff;
  assign sq      = prod[SQ_W-1:0];
  assign total   = {1'b0, sum} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq};
  assign tot_sat = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
  assign ovf_new = ovf | total[SUM_W];

  // restoring square root, two radicand bits per step; low 16 bits are zero
  assign rem_sh = {rem[REM_W-3:0], xreg[SUM_W-1:SUM_W-2]};
  assign trial  = {root, 2'b01};
  assign ge     = rem_sh >= trial;

  assign sts.root_last = cnt == CNT_W'(ROOT_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      ovf <= 1'b0;
    end else if (cmd.accept) begin
      if (cmd.start) begin
        sum <= '0;
        ovf <= 1'b0;
      end else begin
        sum <= tot_sat;
        ovf <= ovf_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      xreg     <= tot_sat;
      root_ovf <= ovf_new;
      rem      <= '0;
      root     <= '0;
      cnt      <= '0;
    end else if (cmd.step) begin
      xreg <= {xreg[SUM_W-3:0], 2'b00};
      rem  <= ge ? rem_sh - trial : rem_sh;
      root <= {root[ROOT_W-2:0], ge};
      cnt  <= cnt + CNT_W'(1);
    end
    if (cmd.load) begin
      distance      <= root;
      sum_saturated <= root_ovf;
    end
  end

endmodule

// File: rtl/ied_controller.sv
`include "int8_euclidean_distance_assert.svh"

module ied_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           last_elem,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ied_pkg::sts_t  sts,
  output ied_pkg::cmd_t  cmd
);
  import ied_pkg::*;

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready   = state == ST_ACC;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.start  = cmd.accept && last_elem;
  assign cmd.step   = state == ST_ROOT;
  assign cmd.load   = (state == ST_LOAD) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACC:  if (cmd.start) state_next = ST_ROOT;
      ST_ROOT: if (sts.root_last) state_next = ST_LOAD;
      ST_LOAD: if (cmd.load) state_next = ST_ACC;
      default: state_next = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `IED_ASSERT_NEXT(a_last_starts_root, clk, rst, cmd.start, state == ST_ROOT)
  `IED_ASSERT_NEXT(a_root_ends_in_load, clk, rst, cmd.step && sts.root_last, state == ST_LOAD)
  `IED_ASSERT_NEXT(a_load_shows_result, clk, rst, cmd.load, out_valid && in_ready)
  `IED_ASSERT_IMPL(a_no_accept_in_root, clk, rst, cmd.step, !cmd.accept && !cmd.load)

endmodule

// File: rtl/int8_euclidean_distance.sv
// The distance is valid after the transfer of the last pair, once the bit-serial square
//   root has run and the output register is loaded; the load waits until the old result is taken.
// Throughput: one pair per cycle while accumulating; no pair is taken from the last pair until
//   the load, so the one-bit-per-cycle square root unit sets the pace between vectors.
// Reset (rst, synchronous, active high) clears the running sum, the overflow
//   flag, the controller state and the output valid.
module int8_euclidean_distance (
  input  logic        clk,
  input  logic        rst,
  ied_pair_if.sink    pairs,
  ied_dist_if.source  result
);
  import ied_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ied_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pairs.valid),
    .last_elem (pairs.last_elem),
    .in_ready  (pairs.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ied_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .elem_a        (pairs.elem_a),
    .elem_b        (pairs.elem_b),
    .sts           (sts),
    .distance      (result.distance),
    .sum_saturated (result.sum_saturated)
  );

endmodule
